// ===== sv/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the Taylor series evaluator: field widths,
// series codes, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int ARG_W      = 32;
  localparam int SUM_W      = 48;
  localparam int CFG_W      = 6;
  localparam int RECIP_BITS = 30;
  localparam int STEP_W     = 3;

  localparam logic [CFG_W-1:0] LAST_INDEX_RST = CFG_W'(15);
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  typedef enum logic [1:0] {
    FN_SIN  = 2'd0,
    FN_COS  = 2'd1,
    FN_EXP  = 2'd2,
    FN_SINH = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_MUL_SQ    = 3'd1,
    OP_MUL_RATIO = 3'd2,
    OP_MUL_TERM  = 3'd3,
    OP_ACC       = 3'd4,
    OP_EMIT      = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_IDLE      = 3'd2,
    COND_PAST_LAST = 3'd3,
    COND_FIRST     = 3'd4
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_SQ    = 3'd1;
  localparam step_t ST_CHECK = 3'd2;
  localparam step_t ST_FIRST = 3'd3;
  localparam step_t ST_RATIO = 3'd4;
  localparam step_t ST_TERM  = 3'd5;
  localparam step_t ST_ACC   = 3'd6;
  localparam step_t ST_EMIT  = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  wait_mul;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic mul_go;
  } seq_ctrl_t;

  typedef struct packed {
    logic start;
    logic past_last;
    logic first;
    logic mul_done;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_NONE, target: ST_IDLE, wait_mul: 1'b0};
    case (s)
      ST_IDLE:  w = '{op: OP_NOP,       cond: COND_IDLE,      target: ST_IDLE,  wait_mul: 1'b0};
      ST_SQ:    w = '{op: OP_MUL_SQ,    cond: COND_NONE,      target: ST_IDLE,  wait_mul: 1'b1};
      ST_CHECK: w = '{op: OP_NOP,       cond: COND_PAST_LAST, target: ST_EMIT,  wait_mul: 1'b0};
      ST_FIRST: w = '{op: OP_NOP,       cond: COND_FIRST,     target: ST_ACC,   wait_mul: 1'b0};
      ST_RATIO: w = '{op: OP_MUL_RATIO, cond: COND_NONE,      target: ST_IDLE,  wait_mul: 1'b1};
      ST_TERM:  w = '{op: OP_MUL_TERM,  cond: COND_NONE,      target: ST_IDLE,  wait_mul: 1'b1};
      ST_ACC:   w = '{op: OP_ACC,       cond: COND_ALWAYS,    target: ST_CHECK, wait_mul: 1'b0};
      ST_EMIT:  w = '{op: OP_EMIT,      cond: COND_ALWAYS,    target: ST_IDLE,  wait_mul: 1'b0};
      default:  w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: ST_IDLE,  wait_mul: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/tse_mul.sv =====
// ----------------------------------------------------------------------------
// tse_mul
// Multi-cycle signed 48x48 multiplier: four 24x24 partial products on one
// multiplier, then a right shift, saturation to 48 bits and the sign.
// ----------------------------------------------------------------------------
module tse_mul #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic                             frac_sh,
  input  logic signed [tse_pkg::SUM_W-1:0] a,
  input  logic signed [tse_pkg::SUM_W-1:0] b,
  output logic                             done,
  output logic signed [tse_pkg::SUM_W-1:0] res,
  output logic                             sat
);
  import tse_pkg::*;

  localparam int HALF_W = SUM_W / 2;
  localparam int PROD_W = 2 * SUM_W;
  localparam logic [2:0] CNT_LAST_PP = 3'd3;
  localparam logic [2:0] CNT_LAST_ADD = 3'd4;
  localparam logic [2:0] CNT_FIN = 3'd5;

  logic [SUM_W-1:0]    ua;
  logic [SUM_W-1:0]    ub;
  logic                neg;
  logic                shsel;
  logic                active;
  logic [2:0]          cnt;
  logic [2*HALF_W-1:0] pp;
  logic [1:0]          pp_wt;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   q;
  logic [PROD_W-1:0]   lim;
  logic [HALF_W-1:0]   a_half;
  logic [HALF_W-1:0]   b_half;
  logic [SUM_W-1:0]    mag;
  logic                over;

  assign a_half = cnt[1] ? ua[SUM_W-1:HALF_W] : ua[HALF_W-1:0];
  assign b_half = cnt[0] ? ub[SUM_W-1:HALF_W] : ub[HALF_W-1:0];

  assign q    = shsel ? (acc >> FRAC_BITS) : (acc >> RECIP_BITS);
  assign lim  = PROD_W'(SUM_MAX) + PROD_W'(neg);
  assign over = q > lim;
  assign mag  = over ? lim[SUM_W-1:0] : q[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (go) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= '0;
      ua     <= a[SUM_W-1] ? SUM_W'(-a) : SUM_W'(a);
      ub     <= b[SUM_W-1] ? SUM_W'(-b) : SUM_W'(b);
      neg    <= a[SUM_W-1] ^ b[SUM_W-1];
      shsel  <= frac_sh;
      acc    <= '0;
    end else if (active) begin
      cnt  <= cnt + 3'd1;
      done <= 1'b0;
      if (cnt <= CNT_LAST_PP) begin
        pp    <= a_half * b_half;
        pp_wt <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      if (cnt >= 3'd1 && cnt <= CNT_LAST_ADD) begin
        acc <= acc + (PROD_W'(pp) << (HALF_W * int'(pp_wt)));
      end
      if (cnt == CNT_FIN) begin
        res    <= neg ? SUM_W'(-mag) : mag;
        sat    <= over;
        done   <= 1'b1;
        active <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== sv/tse_useq.sv =====
// ----------------------------------------------------------------------------
// tse_useq
// Microcode sequencer: step counter over the control ROM, conditional jumps,
// hold on multiply steps until the multiplier reports done.
// ----------------------------------------------------------------------------
module tse_useq (
  input  logic               clk,
  input  logic               rst,
  input  tse_pkg::seq_stat_t stat,
  output tse_pkg::seq_ctrl_t ctrl,
  output logic               busy
);
  import tse_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   take;
  logic   issued;

  assign word     = ucode_rom(step);
  assign busy     = step != ST_IDLE;
  assign ctrl.op  = word.op;
  assign ctrl.mul_go = word.wait_mul && !issued;

  always_comb begin
    unique case (word.cond)
      COND_NONE:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_IDLE:      take = !stat.start;
      COND_PAST_LAST: take = stat.past_last;
      COND_FIRST:     take = stat.first;
      default:        take = 1'b0;
    endcase
  end

  always_comb begin
    if (word.wait_mul && !stat.mul_done) begin
      step_next = step;
    end else if (take) begin
      step_next = word.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      step <= step_next;
      if (ctrl.mul_go) begin
        issued <= 1'b1;
      end else if (stat.mul_done) begin
        issued <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/taylor_series_evaluator.sv =====
// ----------------------------------------------------------------------------
// taylor_series_evaluator
// Truncated Taylor sum of sin, cos, exp or sinh in fixed point, run by a
// microcoded sequencer over one shared multi-cycle multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive func and arg_x (Q4.28) and raise start; the beat is taken at
//   the edge where start is high and busy is low. busy stays high until the
//   result beat is out.
//   Output: done is high for exactly one cycle with series_sum (Q20.28,
//   saturated) and saturated; the receiver cannot stall, so take it then.
//   Config: cfg_we/cfg_wdata write last_index (reset 15); write only while
//   busy is low.
//   Timing: each multiply runs on a 24x24 multiplier used four times. After
//   the accept come x*x, the first term, then for each later term two
//   multiplies, index checks and the add, and last the final index check
//   and the emit; with no terms summed, only x*x, the check and the emit.
//   The sine at the default last index sums 8 terms.
//   One item at a time; the next beat is taken in the strobe cycle.
//   Reset: sequencer returns to idle, last_index goes to 15, no strobe.
// ----------------------------------------------------------------------------
module taylor_series_evaluator #(
  parameter int MAX_INDEX = 63,
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic signed [tse_pkg::ARG_W-1:0] arg_x,
  input  logic                             cfg_we,
  input  logic [tse_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                             done,
  output logic signed [tse_pkg::SUM_W-1:0] series_sum,
  output logic                             saturated
);
  import tse_pkg::*;

  localparam int IDXW      = $clog2(MAX_INDEX + 3);
  localparam int KW        = $clog2(MAX_INDEX);
  localparam int ROM_DEPTH = 1 << KW;
  localparam int CMP_W     = (IDXW > CFG_W) ? IDXW : CFG_W + 1;

  logic [CFG_W-1:0]        last_index;
  func_t                   fn;
  logic signed [SUM_W-1:0] x;
  logic signed [SUM_W-1:0] x2;
  logic signed [SUM_W-1:0] ratio;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum;
  logic                    sat;
  logic [IDXW-1:0]         idx;
  logic [IDXW-1:0]         last;
  logic [IDXW-1:0]         last_next;

  logic [RECIP_BITS:0] recip_pair [ROM_DEPTH];
  logic [RECIP_BITS:0] recip_lin  [ROM_DEPTH];
  logic [IDXW-1:0]     k_full;
  logic [KW-1:0]       k;
  logic [RECIP_BITS:0] recip;

  logic                    accept;
  logic signed [SUM_W-1:0] sx_arg;
  logic signed [SUM_W-1:0] one;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic                    sum_clip;

  seq_stat_t               stat;
  seq_ctrl_t               ctrl;
  logic                    mul_done;
  logic                    mul_sat;
  logic                    mul_frac;
  logic signed [SUM_W-1:0] mul_a;
  logic signed [SUM_W-1:0] mul_b;
  logic signed [SUM_W-1:0] mul_res;

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_recip
    localparam logic [63:0] PD = (g == 0) ? 64'd1 : 64'(g) * 64'(g + 1);
    localparam logic [63:0] LD = (g == 0) ? 64'd1 : 64'(g);
    localparam logic [63:0] PV = ((64'd1 << RECIP_BITS) + PD / 64'd2) / PD;
    localparam logic [63:0] LV = ((64'd1 << RECIP_BITS) + LD / 64'd2) / LD;
    assign recip_pair[g] = PV[RECIP_BITS:0];
    assign recip_lin[g]  = LV[RECIP_BITS:0];
  end

  assign accept = start && !busy;
  assign sx_arg = {{(SUM_W-ARG_W){arg_x[ARG_W-1]}}, arg_x};
  assign one    = SUM_W'(1) << FRAC_BITS;

  assign last_next = (CMP_W'(last_index) > CMP_W'(MAX_INDEX)) ?
                     IDXW'(MAX_INDEX) : IDXW'(last_index);

  assign k_full = idx - ((fn == FN_COS) ? IDXW'(2) : IDXW'(1));
  assign k      = k_full[KW-1:0];
  assign recip  = (fn == FN_EXP) ? recip_lin[k] : recip_pair[k];

  assign sum_wide = {sum[SUM_W-1], sum} + {term[SUM_W-1], term};
  assign sum_clip = sum_wide[SUM_W] != sum_wide[SUM_W-1];
  assign sum_next = !sum_clip ? sum_wide[SUM_W-1:0] :
                    sum_wide[SUM_W] ? ~SUM_MAX : SUM_MAX;

  always_comb begin
    mul_a    = x;
    mul_b    = x;
    mul_frac = 1'b1;
    case (ctrl.op)
      OP_MUL_RATIO: begin
        mul_a    = (fn == FN_EXP) ? x : x2;
        mul_b    = SUM_W'(recip);
        mul_frac = 1'b0;
      end
      OP_MUL_TERM: begin
        mul_a = term;
        mul_b = ratio;
      end
      default: begin
        mul_a    = x;
        mul_b    = x;
        mul_frac = 1'b1;
      end
    endcase
  end

  assign stat.start     = start;
  assign stat.past_last = idx > last;
  assign stat.first     = idx == IDXW'(1);
  assign stat.mul_done  = mul_done;

  tse_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  tse_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (ctrl.mul_go),
    .frac_sh (mul_frac),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .res     (mul_res),
    .sat     (mul_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= LAST_INDEX_RST;
    end else if (cfg_we) begin
      last_index <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.op == OP_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fn   <= func_t'(func);
      x    <= sx_arg;
      sum  <= '0;
      sat  <= 1'b0;
      idx  <= IDXW'(1);
      last <= last_next;
      term <= (func_t'(func) == FN_COS || func_t'(func) == FN_EXP) ? one : sx_arg;
    end else begin
      if (mul_done) begin
        sat <= sat | mul_sat;
        case (ctrl.op)
          OP_MUL_SQ:    x2 <= mul_res;
          OP_MUL_RATIO: ratio <= (fn == FN_SIN || fn == FN_COS) ? SUM_W'(-mul_res) : mul_res;
          OP_MUL_TERM:  term <= mul_res;
          default:      x2 <= x2;
        endcase
      end
      if (ctrl.op == OP_ACC) begin
        sum <= sum_next;
        sat <= sat | sum_clip;
        idx <= idx + ((fn == FN_EXP) ? IDXW'(1) : IDXW'(2));
      end
    end
  end

  assign series_sum = sum;
  assign saturated  = sat;

endmodule

// ===== sv/tse_checker.sv =====
// ----------------------------------------------------------------------------
// tse_checker
// Port-level checks of the start/busy/done handshake, bound to the top level.
// ----------------------------------------------------------------------------
module tse_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic signed [tse_pkg::SUM_W-1:0] series_sum,
  input logic                             saturated
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({series_sum, saturated}))
    else $error("result beat carries unknown bits");

endmodule

bind taylor_series_evaluator tse_checker u_tse_checker (.*);

// ===== dv/taylor_series_evaluator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_series_evaluator_test
// Self-checking bench for the Taylor series evaluator. Each beat taken on the
// command port is run through a local fixed-point model of the truncated
// sin/cos/exp/sinh sums, and the expected sum and clip flag are queued. Every
// done strobe is checked against the oldest entry. Directed beats hit the
// argument extremes at several last_index settings, including zero and the
// top. Random phases follow, with random gaps, drain pauses and index changes.
// ----------------------------------------------------------------------------
module taylor_series_evaluator_test;
  import tse_pkg::*;

  localparam int MAX_INDEX = 63;
  localparam int FRAC_BITS = 28;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [ARG_W-1:0] X_MAX = 32'h7FFF_FFFF;
  localparam logic [ARG_W-1:0] X_MIN = 32'h8000_0000;
  localparam logic [ARG_W-1:0] X_ONE = 32'h1000_0000;
  localparam logic [ARG_W-1:0] X_NEG_ONE = 32'hF000_0000;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } taylor_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  func_t func;
  logic signed [ARG_W-1:0] arg_x;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic done;
  logic signed [SUM_W-1:0] series_sum;
  logic saturated;

  taylor_result_t pending_sums[$];
  logic [CFG_W-1:0] last_index_copy;
  int errors = 0;
  int idle_cycles = 0;

  taylor_series_evaluator #(
    .MAX_INDEX(MAX_INDEX),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .arg_x     (arg_x),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .series_sum(series_sum),
    .saturated (saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip_mul(input longint a, input longint b, input int sh,
                                      inout logic sat);
    logic neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [127:0] p;
    logic [127:0] lim;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ua} * {64'd0, ub};
    p = p >> sh;
    lim = {80'd0, SUM_MAX};
    if (neg) lim = lim + 128'd1;
    if (p > lim) begin
      sat = 1'b1;
      p = lim;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint recip_of(input longint d);
    longint dd;
    dd = (d == 0) ? 1 : d;
    return ((longint'(1) << RECIP_BITS) + dd / 2) / dd;
  endfunction

  function automatic taylor_result_t taylor_sum(input func_t f,
                                                input logic signed [ARG_W-1:0] x,
                                                input logic [CFG_W-1:0] idx);
    taylor_result_t r;
    logic sat;
    int last;
    int step;
    longint xv;
    longint x2;
    longint term;
    longint ratio;
    longint sum;
    longint smax;
    sat = 1'b0;
    last = (int'(idx) > MAX_INDEX) ? MAX_INDEX : int'(idx);
    step = (f == FN_EXP) ? 1 : 2;
    smax = longint'(SUM_MAX);
    xv = longint'(x);
    x2 = clip_mul(xv, xv, FRAC_BITS, sat);
    term = (f == FN_COS || f == FN_EXP) ? (longint'(1) << FRAC_BITS) : xv;
    sum = 0;
    for (int i = 1; i <= last; i += step) begin
      if (i > 1) begin
        case (f)
          FN_SIN:  ratio = -clip_mul(x2, recip_of((i - 1) * i), RECIP_BITS, sat);
          FN_COS:  ratio = -clip_mul(x2, recip_of((i - 2) * (i - 1)), RECIP_BITS, sat);
          FN_EXP:  ratio = clip_mul(xv, recip_of(i - 1), RECIP_BITS, sat);
          default: ratio = clip_mul(x2, recip_of((i - 1) * i), RECIP_BITS, sat);
        endcase
        term = clip_mul(term, ratio, FRAC_BITS, sat);
      end
      sum = sum + term;
      if (sum > smax) begin
        sum = smax;
        sat = 1'b1;
      end else if (sum < -smax - 1) begin
        sum = -smax - 1;
        sat = 1'b1;
      end
    end
    r.sum = sum[SUM_W-1:0];
    r.sat = sat;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  function automatic logic [ARG_W-1:0] pick_arg();
    int r;
    logic [ARG_W-1:0] v;
    r = $urandom_range(0, 99);
    v = $urandom;
    if (r < 40) return v;
    if (r < 70) return $signed(v) >>> $urandom_range(1, 8);
    if (r < 85) return $signed(v) >>> $urandom_range(9, 31);
    case ($urandom_range(0, 4))
      0: return X_MAX;
      1: return X_MIN;
      2: return X_ONE;
      3: return X_NEG_ONE;
      default: return '0;
    endcase
  endfunction

  task automatic send_beat(input func_t f, input logic [ARG_W-1:0] x, input int gap);
    start <= 1'b1;
    func <= f;
    arg_x <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_sums.push_back(taylor_sum(f, x, last_index_copy));
    if (gap > 0) begin
      start <= 1'b0;
      func <= func_t'($urandom_range(0, 3));
      arg_x <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_last_index(input logic [CFG_W-1:0] v);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    last_index_copy = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= $urandom;
  endtask

  task automatic test_default_index();
    for (int f = 0; f < 4; f++) begin
      send_beat(func_t'(f), X_MAX, pick_gap());
      send_beat(func_t'(f), X_MIN, pick_gap());
    end
    send_beat(FN_EXP, '0, 0);
    send_beat(FN_SIN, '0, 2);
  endtask

  task automatic test_zero_index();
    write_last_index(6'd0);
    send_beat(FN_EXP, X_MAX, 0);
    send_beat(FN_SIN, X_MIN, 1);
  endtask

  task automatic test_one_index();
    write_last_index(6'd1);
    for (int f = 0; f < 4; f++) send_beat(func_t'(f), X_NEG_ONE, f);
  endtask

  task automatic test_top_index();
    write_last_index(6'd63);
    for (int f = 0; f < 4; f++) send_beat(func_t'(f), X_MAX, 0);
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] idx, input int count);
    logic steady;
    write_last_index(idx);
    steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      send_beat(func_t'($urandom_range(0, 3)), pick_arg(), steady ? 0 : pick_gap());
      if ($urandom_range(0, 49) == 0) settle_idle();
    end
  endtask

  task automatic test_random_mix();
    run_random_phase(6'd2, 150);
    run_random_phase(6'd3, 150);
    run_random_phase(6'd63, 100);
    run_random_phase(6'd1, 100);
    run_random_phase(6'd0, 50);
    for (int p = 0; p < 9; p++) run_random_phase(CFG_W'($urandom_range(1, 20)), 150);
    run_random_phase(CFG_W'($urandom_range(21, 62)), 50);
  endtask

  always @(posedge clk) begin
    taylor_result_t e;
    if (!rst && done) begin
      if (pending_sums.size() == 0) begin
        $display("%0t unexpected result beat: series_sum %0d saturated %0b",
                 $time, series_sum, saturated);
        errors++;
      end else begin
        e = pending_sums.pop_front();
        if (series_sum !== e.sum) begin
          $display("%0t series_sum mismatch: expected %0d actual %0d",
                   $time, e.sum, series_sum);
          errors++;
        end
        if (saturated !== e.sat) begin
          $display("%0t saturated mismatch: expected %0b actual %0b",
                   $time, e.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FN_SIN;
    arg_x = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    last_index_copy = LAST_INDEX_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_index();
    test_zero_index();
    test_one_index();
    test_top_index();
    test_random_mix();
    settle_idle();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
